// ===== src/fldarb_pkg.sv =====
// shared types, constants and codes for the weighted drain arbiter
package fldarb_pkg;

    // default number of entries in each store
    localparam int STORE_DEPTH_DEF = 32;

    // payload widths
    localparam int ID_W    = 16;
    localparam int RATIO_W = 8;
    localparam int MODE_W  = 2;
    localparam int RESP_W  = 2;

    // apb register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_RATIO = 1'b0;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd1;

    // input transaction kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_PUSH  = 2'd1,
        MODE_DRAIN = 2'd2
    } mode_t;

    // result status codes
    typedef enum logic [RESP_W-1:0] {
        RESP_STORED = 2'd0,
        RESP_FULL   = 2'd1,
        RESP_SERVED = 2'd2,
        RESP_EMPTY  = 2'd3
    } resp_code_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       wr_gen;
        logic       wr_pri;
        logic       resp_load;
        resp_code_t resp_code;
        logic       drain_start;
        logic       drain_step;
        logic       drain_emit;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic gen_full;
        logic pri_full;
        logic both_empty;
        logic step_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/fifo_lifo_weighted_drain_arbiter_top.sv =====
// Weighted drain arbiter over a general fifo and a priority stack. An add
// (tuser 0) or push (tuser 1) transaction writes the identifier into its
// store and gives one result in the next cycle; these are accepted every
// cycle while the output register is free. A drain (tuser 2) serves up to
// general_per_priority fifo entries, then one stack entry, in rounds until
// both stores are empty; each served entry is a registered store read, then
// the output register load, which waits while that register is blocked. A
// drain holds the input until its last entry is loaded; a drain of empty
// stores gives one "nothing to drain" result. Tuser 3 is taken and dropped.
// A register value of zero acts as one. The stores need no clearing after reset.
module fifo_lifo_weighted_drain_arbiter_top
    import fldarb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ID_W-1:0]     s_tdata,   // [15:0] store_id
    input  logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ID_W-1:0]     m_tdata,   // [15:0] served_id
    output logic [2:0]          m_tuser,   // [0] from_priority, [2:1] status
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;

    // controller
    fldarb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    fldarb_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .store_id   (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    // input is only taken when the output register can receive its result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
    else $error("input accepted while output register is blocked");

    // a waiting non-final result means the drain is still running, so input stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input opened in the middle of a drain");

    // only served entries can be followed by more results
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[2:1] != RESP_SERVED)) |-> m_tlast)
    else $error("store or empty result without last flag");

    // stack flag is only set on served entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == RESP_SERVED))
    else $error("priority flag on a non-served result");
`endif

endmodule

// ===== src/fldarb_dp.sv =====
// datapath: store memories, occupancy counters, ratio register and output register
module fldarb_dp
    import fldarb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    input  logic [ID_W-1:0]     store_id,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ID_W-1:0]     m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    // store memories and their registered read data
    logic [ID_W-1:0] gen_mem_reg [STORE_DEPTH];
    logic [ID_W-1:0] pri_mem_reg [STORE_DEPTH];
    logic [ID_W-1:0] gen_rd_reg;
    logic [ID_W-1:0] pri_rd_reg;

    // control state
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [CW-1:0]      gen_count_reg, gen_count_next;
    logic [AW-1:0]      gen_head_reg, gen_head_next;
    logic [CW-1:0]      pri_count_reg, pri_count_next;
    logic [RATIO_W-1:0] taken_reg, taken_next;
    logic               src_pri_reg, src_pri_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;

    // output payload
    logic [ID_W-1:0]    out_id_reg;
    logic               out_prio_reg;
    resp_code_t         out_resp_reg;
    logic               out_last_reg;

    logic               cfg_wr;
    logic [RATIO_W-1:0] ratio_eff;
    logic [CW:0]        gen_sum;
    logic [AW-1:0]      gen_wr_idx;
    logic [AW-1:0]      gen_head_inc;
    logic [AW-1:0]      pri_pop_idx;
    logic               take_gen;
    logic               step_last;
    logic               out_free;

    // configuration register access
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_RATIO);
    assign prdata = (paddr[2] == REG_IDX_RATIO) ? PDATA_W'(ratio_reg) : '0;
    assign ratio_eff = (ratio_reg == '0) ? RATIO_W'(1) : ratio_reg;

    // fifo tail slot, head wrap and stack top
    assign gen_sum = (CW+1)'(gen_head_reg) + (CW+1)'(gen_count_reg);
    assign gen_wr_idx = (gen_sum >= (CW+1)'(STORE_DEPTH))
                        ? AW'(gen_sum - (CW+1)'(STORE_DEPTH)) : AW'(gen_sum);
    assign gen_head_inc = (gen_head_reg == AW'(STORE_DEPTH - 1))
                          ? '0 : gen_head_reg + AW'(1);
    assign pri_pop_idx = AW'(pri_count_reg - CW'(1));

    // round selection: general while under ratio, or while the stack is empty
    assign take_gen = (gen_count_reg != '0) &&
                      ((taken_reg < ratio_eff) || (pri_count_reg == '0));
    assign step_last = take_gen
                       ? ((gen_count_reg == CW'(1)) && (pri_count_reg == '0))
                       : ((pri_count_reg == CW'(1)) && (gen_count_reg == '0));

    assign out_free = !out_valid_reg || m_tready;

    // status to controller
    assign status.gen_full   = (gen_count_reg == CW'(STORE_DEPTH));
    assign status.pri_full   = (pri_count_reg == CW'(STORE_DEPTH));
    assign status.both_empty = (gen_count_reg == '0) && (pri_count_reg == '0);
    assign status.step_last  = last_reg;
    assign status.out_free   = out_free;

    // memory writes and reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_gen)
        begin
            gen_mem_reg[gen_wr_idx] <= store_id;
        end
        if (cmd.wr_pri)
        begin
            pri_mem_reg[AW'(pri_count_reg)] <= store_id;
        end
        if (cmd.drain_step && take_gen)
        begin
            gen_rd_reg <= gen_mem_reg[gen_head_reg];
        end
        if (cmd.drain_step && !take_gen)
        begin
            pri_rd_reg <= pri_mem_reg[pri_pop_idx];
        end
    end

    // next values of counters and drain state
    always_comb
    begin
        ratio_next     = ratio_reg;
        gen_count_next = gen_count_reg;
        gen_head_next  = gen_head_reg;
        pri_count_next = pri_count_reg;
        taken_next     = taken_reg;
        src_pri_next   = src_pri_reg;
        last_next      = last_reg;
        if (cfg_wr)
        begin
            ratio_next = pwdata[RATIO_W-1:0];
        end
        if (cmd.wr_gen)
        begin
            gen_count_next = gen_count_reg + CW'(1);
        end
        if (cmd.wr_pri)
        begin
            pri_count_next = pri_count_reg + CW'(1);
        end
        if (cmd.drain_start)
        begin
            taken_next = '0;
        end
        if (cmd.drain_step)
        begin
            last_next = step_last;
            if (take_gen)
            begin
                gen_count_next = gen_count_reg - CW'(1);
                gen_head_next  = (gen_count_reg == CW'(1)) ? '0 : gen_head_inc;
                taken_next     = (taken_reg >= ratio_eff) ? RATIO_W'(1)
                                                          : taken_reg + RATIO_W'(1);
                src_pri_next   = 1'b0;
            end
            else
            begin
                pri_count_next = pri_count_reg - CW'(1);
                taken_next     = '0;
                src_pri_next   = 1'b1;
            end
        end
    end

    // output register occupancy
    always_comb
    begin
        if (cmd.resp_load || cmd.drain_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            gen_count_reg <= '0;
            gen_head_reg  <= '0;
            pri_count_reg <= '0;
            taken_reg     <= '0;
            src_pri_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ratio_reg     <= ratio_next;
            gen_count_reg <= gen_count_next;
            gen_head_reg  <= gen_head_next;
            pri_count_reg <= pri_count_next;
            taken_reg     <= taken_next;
            src_pri_reg   <= src_pri_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload load
    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            out_id_reg   <= '0;
            out_prio_reg <= 1'b0;
            out_resp_reg <= cmd.resp_code;
            out_last_reg <= 1'b1;
        end
        else if (cmd.drain_emit)
        begin
            out_id_reg   <= src_pri_reg ? pri_rd_reg : gen_rd_reg;
            out_prio_reg <= src_pri_reg;
            out_resp_reg <= RESP_SERVED;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = {out_resp_reg, out_prio_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/fldarb_ctrl.sv =====
// controller state machine: input acceptance and drain sequencing
module fldarb_ctrl
    import fldarb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MODE_W-1:0] s_tuser,
    input  dp_status_t        status,
    output dp_cmd_t           cmd
);

    state_t state_reg, state_next;
    mode_t  mode;

    assign mode = mode_t'(s_tuser);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd.wr_gen      = 1'b0;
        cmd.wr_pri      = 1'b0;
        cmd.resp_load   = 1'b0;
        cmd.resp_code   = RESP_STORED;
        cmd.drain_start = 1'b0;
        cmd.drain_step  = 1'b0;
        cmd.drain_emit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = status.out_free;
                if (s_tvalid && status.out_free)
                begin
                    unique case (mode)
                        MODE_ADD:
                        begin
                            cmd.resp_load = 1'b1;
                            cmd.resp_code = status.gen_full ? RESP_FULL : RESP_STORED;
                            cmd.wr_gen    = !status.gen_full;
                        end
                        MODE_PUSH:
                        begin
                            cmd.resp_load = 1'b1;
                            cmd.resp_code = status.pri_full ? RESP_FULL : RESP_STORED;
                            cmd.wr_pri    = !status.pri_full;
                        end
                        MODE_DRAIN:
                        begin
                            if (status.both_empty)
                            begin
                                cmd.resp_load = 1'b1;
                                cmd.resp_code = RESP_EMPTY;
                            end
                            else
                            begin
                                cmd.drain_start = 1'b1;
                                state_next      = ST_READ;
                            end
                        end
                        default:
                        begin
                            // unused mode: transaction is taken with no result
                            cmd.resp_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.drain_step = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.drain_emit = 1'b1;
                    state_next     = status.step_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the weighted drain arbiter over stream and apb ports
module tb_top;
    import fldarb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STORE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] RATIO_ADDR = PADDR_W'(4 * int'(REG_IDX_RATIO));

    // one expected result of the arbiter
    typedef struct {
        logic [ID_W-1:0] served_id;
        logic            from_priority;
        resp_code_t      status;
        logic            last;
    } arb_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [ID_W-1:0]    s_tdata;   // [15:0] store_id
    logic [MODE_W-1:0]  s_tuser;   // [1:0] mode
    logic               m_tvalid;
    logic               m_tready;
    logic [ID_W-1:0]    m_tdata;   // [15:0] served_id
    logic [2:0]         m_tuser;   // [0] from_priority, [2:1] status
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // shadow of the arbiter state
    logic [ID_W-1:0]    fifo_ids [DEPTH];
    logic [ID_W-1:0]    stack_ids [DEPTH];
    int                 fifo_head;
    int                 fifo_cnt;
    int                 stack_cnt;
    logic [RATIO_W-1:0] drain_ratio;

    arb_result_t        pending_results [$];
    int                 fail_count;
    int                 items_sent;
    int                 results_checked;
    int                 ratio_writes;
    int                 cycle_count;
    int                 stall_left;
    bit                 idle_on;

    fifo_lifo_weighted_drain_arbiter_top #(
        .STORE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result checker and receiver backpressure
    always @(posedge clk)
    begin
        arb_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: served_id %h status %0d", m_tdata, m_tuser[2:1]);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (m_tdata !== exp_res.served_id)
                begin
                    $error("served_id expected %h actual %h", exp_res.served_id, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_res.from_priority)
                begin
                    $error("from_priority expected %0d actual %0d",
                           exp_res.from_priority, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[2:1] !== exp_res.status)
                begin
                    $error("status expected %0d actual %0d", exp_res.status, m_tuser[2:1]);
                    fail_count++;
                end
                if (m_tlast !== exp_res.last)
                begin
                    $error("last expected %0d actual %0d", exp_res.last, m_tlast);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic expect_result(input logic [ID_W-1:0] id, input logic prio,
                                 input resp_code_t status, input logic last);
        arb_result_t res;
        res.served_id = id;
        res.from_priority = prio;
        res.status = status;
        res.last = last;
        pending_results.push_back(res);
    endtask

    // predict the results of one accepted transaction
    task automatic arbitrate(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        int ratio_eff;
        int taken;
        logic [ID_W-1:0] out_id;
        ratio_eff = (drain_ratio == 0) ? 1 : int'(drain_ratio);
        if (mode == MODE_ADD)
        begin
            if (fifo_cnt >= DEPTH)
                expect_result('0, 1'b0, RESP_FULL, 1'b1);
            else
            begin
                fifo_ids[(fifo_head + fifo_cnt) % DEPTH] = id;
                fifo_cnt++;
                expect_result('0, 1'b0, RESP_STORED, 1'b1);
            end
        end
        else if (mode == MODE_PUSH)
        begin
            if (stack_cnt >= DEPTH)
                expect_result('0, 1'b0, RESP_FULL, 1'b1);
            else
            begin
                stack_ids[stack_cnt] = id;
                stack_cnt++;
                expect_result('0, 1'b0, RESP_STORED, 1'b1);
            end
        end
        else if (mode == MODE_DRAIN)
        begin
            if (fifo_cnt == 0 && stack_cnt == 0)
                expect_result('0, 1'b0, RESP_EMPTY, 1'b1);
            // rounds of up to ratio fifo entries, then one stack entry
            while (fifo_cnt > 0 || stack_cnt > 0)
            begin
                taken = 0;
                while (taken < ratio_eff && fifo_cnt > 0)
                begin
                    out_id = fifo_ids[fifo_head];
                    fifo_head = (fifo_head + 1) % DEPTH;
                    fifo_cnt--;
                    taken++;
                    expect_result(out_id, 1'b0, RESP_SERVED, fifo_cnt == 0 && stack_cnt == 0);
                end
                if (fifo_cnt == 0)
                    fifo_head = 0;
                if (stack_cnt > 0)
                begin
                    stack_cnt--;
                    out_id = stack_ids[stack_cnt];
                    expect_result(out_id, 1'b1, RESP_SERVED, fifo_cnt == 0 && stack_cnt == 0);
                end
            end
        end
    endtask

    // send one transaction, with an optional random gap first
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= id;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        arbitrate(mode, id);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    // stop sending and wait until every result is in and the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RATIO_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        drain_ratio = data[RATIO_W-1:0];
        ratio_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= RATIO_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(drain_ratio))
        begin
            $error("general_per_priority expected %0d actual %0d", drain_ratio, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_ratio(input logic [RATIO_W-1:0] value);
        settle();
        reg_write(PDATA_W'(value));
        reg_check();
    endtask

    // extremes of the ids, all modes, empty drain, zero and max ratio
    task automatic test_directed();
        reg_check();
        send_item(MODE_DRAIN, 16'h1234);
        send_item(MODE_UNUSED, 16'hFFFF);
        send_item(MODE_ADD, 16'h0000);
        send_item(MODE_ADD, 16'hFFFF);
        send_item(MODE_PUSH, 16'hFFFF);
        send_item(MODE_PUSH, 16'h0000);
        send_item(MODE_ADD, 16'h8000);
        send_item(MODE_PUSH, 16'h0001);
        send_item(MODE_DRAIN, 16'hFFFF);
        set_ratio(8'd255);
        send_item(MODE_ADD, 16'h00AA);
        send_item(MODE_PUSH, 16'h5555);
        send_item(MODE_ADD, 16'hAA00);
        send_item(MODE_PUSH, 16'h7FFF);
        send_item(MODE_ADD, 16'h0F0F);
        send_item(MODE_DRAIN, 16'h0000);
        set_ratio(8'd0);
        send_item(MODE_ADD, 16'h0101);
        send_item(MODE_ADD, 16'h0202);
        send_item(MODE_PUSH, 16'hF0F0);
        send_item(MODE_PUSH, 16'hE0E0);
        send_item(MODE_DRAIN, 16'h0000);
        send_item(MODE_DRAIN, 16'h0000);
    endtask

    // fill both stores past full, drain everything, then reuse the slots
    task automatic test_full();
        int k;
        set_ratio(8'd2);
        for (k = 0; k < DEPTH + 2; k++)
            send_item(MODE_ADD, 16'($urandom));
        for (k = 0; k < DEPTH + 2; k++)
            send_item(MODE_PUSH, 16'($urandom));
        send_item(MODE_DRAIN, 16'($urandom));
        send_item(MODE_ADD, 16'($urandom));
        send_item(MODE_ADD, 16'($urandom));
        send_item(MODE_PUSH, 16'($urandom));
        send_item(MODE_DRAIN, 16'($urandom));
    endtask

    // random fill sequences, each closed by a drain, with some noise mixed in
    task automatic run_phase(input int n_items);
        int sent;
        int len;
        int k;
        int pick;
        int add_pct;
        bit long_seq;
        logic [ID_W-1:0] id;
        sent = 0;
        while (sent < n_items)
        begin
            long_seq = ($urandom_range(0, 9) == 0);
            len = long_seq ? $urandom_range(20, 45) : $urandom_range(1, 12);
            if (long_seq)
                add_pct = ($urandom_range(0, 1) == 1) ? 85 : 10;
            else
                add_pct = 55;
            for (k = 0; k < len && sent < n_items; k++)
            begin
                pick = $urandom_range(0, 99);
                id = 16'($urandom);
                if (pick < add_pct)
                    send_item(MODE_ADD, id);
                else if (pick < 90)
                    send_item(MODE_PUSH, id);
                else if (pick < 95)
                    send_item(MODE_UNUSED, id);
                else
                    send_item(MODE_DRAIN, id);
                if (pick < 90 || pick >= 95)
                    sent++;
            end
            send_item(MODE_DRAIN, 16'($urandom));
            sent++;
        end
    endtask

    task automatic test_random();
        set_ratio(8'd1);
        run_phase(30);
        set_ratio(8'd255);
        run_phase(15);
        settle();
        run_phase(15);
        set_ratio(RATIO_W'($urandom_range(2, 6)));
        run_phase(30);
        set_ratio(RATIO_W'($urandom_range(1, 255)));
        run_phase(30);
        // last stretch runs with no idling on either side
        settle();
        idle_on = 1'b0;
        set_ratio(8'd3);
        run_phase(30);
    endtask

    // main sequence
    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_ADD;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        fifo_head = 0;
        fifo_cnt = 0;
        stack_cnt = 0;
        drain_ratio = RATIO_RESET;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        ratio_writes = 0;
        cycle_count = 0;
        stall_left = 0;
        idle_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full();
        test_random();
        settle();

        $display("covered %0d transactions and %0d checked results over %0d ratio settings",
                 items_sent, results_checked, ratio_writes);
        $display("including empty drains, full stores, unused mode and zero and max ratio");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
